/* src/dqp_pkg.sv */
// Shared types and constants for the dotted-quad address parser.
package dqp_pkg;

   typedef logic [2:0] phase_type;
   typedef logic [1:0] base_type;

   // Position within a token
   localparam phase_type PH_BETWEEN = 3'd0;
   localparam phase_type PH_LEAD    = 3'd1;
   localparam phase_type PH_SIGNED  = 3'd2;
   localparam phase_type PH_ZERO    = 3'd3;
   localparam phase_type PH_XPEND   = 3'd4;
   localparam phase_type PH_DIGITS  = 3'd5;
   localparam phase_type PH_DONE    = 3'd6;
   localparam phase_type PH_ENDED   = 3'd7;

   localparam base_type BASE_DEC = 2'd0;
   localparam base_type BASE_OCT = 2'd1;
   localparam base_type BASE_HEX = 2'd2;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_SEVEN = 8'h37;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_UF    = 8'h46;
   localparam logic [7:0] CHAR_UX    = 8'h58;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_LF    = 8'h66;
   localparam logic [7:0] CHAR_LX    = 8'h78;

   localparam int unsigned TOKEN_SLOTS = 4;
   localparam int unsigned BYTE_BITS   = 8;

endpackage

/* src/dotted_quad_to_ipv4_parser_top.sv */
// Dotted-quad IPv4 address parser: one character per transaction, address after the last.
// A character is registered at acceptance and parsed from that register, and the address of a
// string is registered when its last character advances and is then offered on rsp_.
// Throughput: one character per cycle; the parse is one shift-add of the token magnitude.
// A held result stalls the input only while a registered final character waits behind it.
// Reset (synchronous, active high) empties both registers and clears the parse state.
module dotted_quad_to_ipv4_parser_top #(
   parameter int unsigned ACC_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_in,
   input  logic        req_last_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_address
);

   localparam int unsigned WIDE_BITS = ACC_BITS + 4;

   // input register
   logic                in_valid_ff, in_valid_in;
   logic [7:0]          char_ff;
   logic                last_ff;

   // parse state
   logic [ACC_BITS-1:0] token_value_ff, token_value_in;
   logic                overflowed_ff, overflowed_in;
   logic                negative_ff, negative_in;
   dqp_pkg::base_type   number_base_ff, number_base_in;
   dqp_pkg::phase_type  token_phase_ff, token_phase_in;
   logic [2:0]          token_index_ff, token_index_in;
   logic [31:0]         address_sum_ff, address_sum_in;

   // result register
   logic                out_valid_ff, out_valid_in;
   logic [31:0]         address_ff;

   logic                req_take, advance;

   // combinational step
   logic                is_dot, is_nul, is_space, is_sign, is_x;
   logic                is_dec, is_lo, is_up, is_oct;
   logic [3:0]          hex_val;
   logic                acc_en;
   dqp_pkg::base_type   acc_base;
   logic [WIDE_BITS-1:0] wide_tv, wide_sum;
   dqp_pkg::phase_type  phase_cur, phase_1;
   logic                neg_1;
   dqp_pkg::base_type   base_1;
   logic [ACC_BITS-1:0] tv_1;
   logic                ovf_1;
   logic                in_tok_cur, in_tok_1, commit;
   logic [7:0]          commit_byte;
   logic [31:0]         sum_1;
   logic [2:0]          idx_1;

   assign advance   = in_valid_ff && (!last_ff || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = (advance && last_ff) || (out_valid_ff && rsp_stall);

   // character classes
   always_comb begin
      is_dot   = (char_ff == dqp_pkg::CHAR_DOT);
      is_nul   = (char_ff == dqp_pkg::CHAR_NUL);
      is_space = (char_ff == dqp_pkg::CHAR_SPACE) ||
                 (char_ff >= dqp_pkg::CHAR_TAB && char_ff <= dqp_pkg::CHAR_CR);
      is_sign  = (char_ff == dqp_pkg::CHAR_PLUS) || (char_ff == dqp_pkg::CHAR_MINUS);
      is_x     = (char_ff == dqp_pkg::CHAR_LX) || (char_ff == dqp_pkg::CHAR_UX);
      is_dec   = (char_ff >= dqp_pkg::CHAR_ZERO) && (char_ff <= dqp_pkg::CHAR_NINE);
      is_oct   = (char_ff >= dqp_pkg::CHAR_ZERO) && (char_ff <= dqp_pkg::CHAR_SEVEN);
      is_lo    = (char_ff >= dqp_pkg::CHAR_LA) && (char_ff <= dqp_pkg::CHAR_LF);
      is_up    = (char_ff >= dqp_pkg::CHAR_UA) && (char_ff <= dqp_pkg::CHAR_UF);
      if (is_dec) begin
         hex_val = 4'(char_ff - dqp_pkg::CHAR_ZERO);
      end else if (is_lo) begin
         hex_val = 4'(char_ff - dqp_pkg::CHAR_LA + 8'd10);
      end else begin
         hex_val = 4'(char_ff - dqp_pkg::CHAR_UA + 8'd10);
      end
   end

   // phase step for one character
   always_comb begin
      phase_cur = (token_phase_ff == dqp_pkg::PH_BETWEEN) ? dqp_pkg::PH_LEAD : token_phase_ff;
      phase_1   = token_phase_ff;
      neg_1     = negative_ff;
      base_1    = number_base_ff;
      acc_en    = 1'b0;
      acc_base  = number_base_ff;
      in_tok_cur = (token_phase_ff != dqp_pkg::PH_BETWEEN) &&
                   (token_phase_ff != dqp_pkg::PH_ENDED);
      if (token_phase_ff == dqp_pkg::PH_ENDED) begin
         phase_1 = dqp_pkg::PH_ENDED;
      end else if (is_nul) begin
         phase_1 = dqp_pkg::PH_ENDED;
      end else if (is_dot) begin
         phase_1 = dqp_pkg::PH_BETWEEN;
      end else begin
         phase_1 = phase_cur;
         unique case (phase_cur) inside
            dqp_pkg::PH_LEAD, dqp_pkg::PH_SIGNED: begin
               if (phase_cur == dqp_pkg::PH_LEAD && is_space) begin
                  phase_1 = dqp_pkg::PH_LEAD;
               end else if (phase_cur == dqp_pkg::PH_LEAD && is_sign) begin
                  neg_1   = (char_ff == dqp_pkg::CHAR_MINUS);
                  phase_1 = dqp_pkg::PH_SIGNED;
               end else if (char_ff == dqp_pkg::CHAR_ZERO) begin
                  phase_1 = dqp_pkg::PH_ZERO;
               end else if (char_ff >= dqp_pkg::CHAR_ONE && char_ff <= dqp_pkg::CHAR_NINE) begin
                  phase_1  = dqp_pkg::PH_DIGITS;
                  base_1   = dqp_pkg::BASE_DEC;
                  acc_base = dqp_pkg::BASE_DEC;
                  acc_en   = 1'b1;
               end else begin
                  phase_1 = dqp_pkg::PH_DONE;
               end
            end
            dqp_pkg::PH_ZERO: begin
               if (is_x) begin
                  phase_1 = dqp_pkg::PH_XPEND;
               end else if (is_oct) begin
                  phase_1  = dqp_pkg::PH_DIGITS;
                  base_1   = dqp_pkg::BASE_OCT;
                  acc_base = dqp_pkg::BASE_OCT;
                  acc_en   = 1'b1;
               end else begin
                  phase_1 = dqp_pkg::PH_DONE;
               end
            end
            dqp_pkg::PH_XPEND: begin
               if (is_dec || is_lo || is_up) begin
                  phase_1  = dqp_pkg::PH_DIGITS;
                  base_1   = dqp_pkg::BASE_HEX;
                  acc_base = dqp_pkg::BASE_HEX;
                  acc_en   = 1'b1;
               end else begin
                  phase_1 = dqp_pkg::PH_DONE;
               end
            end
            dqp_pkg::PH_DIGITS: begin
               if ((number_base_ff == dqp_pkg::BASE_HEX && (is_dec || is_lo || is_up)) ||
                   (number_base_ff == dqp_pkg::BASE_OCT && is_oct) ||
                   (number_base_ff == dqp_pkg::BASE_DEC && is_dec)) begin
                  acc_en = 1'b1;
               end else begin
                  phase_1 = dqp_pkg::PH_DONE;
               end
            end
            default: begin
               phase_1 = phase_cur;
            end
         endcase
      end
   end

   // shift-add of the magnitude; any carry beyond ACC_BITS saturates the token
   always_comb begin
      wide_tv = {4'b0000, token_value_ff};
      case (acc_base)
         dqp_pkg::BASE_HEX: wide_sum = (wide_tv << 4) + WIDE_BITS'(hex_val);
         dqp_pkg::BASE_OCT: wide_sum = (wide_tv << 3) + WIDE_BITS'(hex_val);
         default:           wide_sum = (wide_tv << 3) + (wide_tv << 1) + WIDE_BITS'(hex_val);
      endcase
      tv_1  = token_value_ff;
      ovf_1 = overflowed_ff;
      if (acc_en && !overflowed_ff) begin
         if (|wide_sum[WIDE_BITS-1:ACC_BITS]) begin
            ovf_1 = 1'b1;
         end else begin
            tv_1 = wide_sum[ACC_BITS-1:0];
         end
      end
   end

   // finish a token at a dot, a NUL or the end of the string
   always_comb begin
      in_tok_1 = (phase_1 != dqp_pkg::PH_BETWEEN) && (phase_1 != dqp_pkg::PH_ENDED);
      commit   = (in_tok_cur && (is_dot || is_nul)) || (last_ff && in_tok_1);
      if (ovf_1) begin
         commit_byte = 8'hFF;
      end else if (neg_1) begin
         commit_byte = 8'h00 - tv_1[7:0];
      end else begin
         commit_byte = tv_1[7:0];
      end
      sum_1 = address_sum_ff;
      idx_1 = token_index_ff;
      if (commit && (token_index_ff < 3'(dqp_pkg::TOKEN_SLOTS))) begin
         idx_1 = token_index_ff + 3'd1;
         unique case (token_index_ff[1:0])
            2'd0:    sum_1[31:24] = commit_byte;
            2'd1:    sum_1[23:16] = commit_byte;
            2'd2:    sum_1[15:8]  = commit_byte;
            default: sum_1[7:0]   = commit_byte;
         endcase
      end
   end

   always_comb begin
      token_value_in = token_value_ff;
      overflowed_in  = overflowed_ff;
      negative_in    = negative_ff;
      number_base_in = number_base_ff;
      token_phase_in = token_phase_ff;
      token_index_in = token_index_ff;
      address_sum_in = address_sum_ff;
      if (advance) begin
         token_phase_in = phase_1;
         token_index_in = idx_1;
         address_sum_in = sum_1;
         if (commit) begin
            token_value_in = '0;
            overflowed_in  = 1'b0;
            negative_in    = 1'b0;
            number_base_in = dqp_pkg::BASE_DEC;
         end else begin
            token_value_in = tv_1;
            overflowed_in  = ovf_1;
            negative_in    = neg_1;
            number_base_in = base_1;
         end
         // drop all state once the string is done
         if (last_ff) begin
            token_phase_in = dqp_pkg::PH_BETWEEN;
            token_index_in = '0;
            address_sum_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         token_value_ff <= '0;
         overflowed_ff  <= 1'b0;
         negative_ff    <= 1'b0;
         number_base_ff <= dqp_pkg::BASE_DEC;
         token_phase_ff <= dqp_pkg::PH_BETWEEN;
         token_index_ff <= '0;
         address_sum_ff <= '0;
      end else begin
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
         token_value_ff <= token_value_in;
         overflowed_ff  <= overflowed_in;
         negative_ff    <= negative_in;
         number_base_ff <= number_base_in;
         token_phase_ff <= token_phase_in;
         token_index_ff <= token_index_in;
         address_sum_ff <= address_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         char_ff <= req_char_in;
         last_ff <= req_last_char;
      end
      if (advance && last_ff) begin
         address_ff <= sum_1;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_address = address_ff;

endmodule

/* src/dqp_checker.sv */
// Port-level checks for the dotted-quad address parser, bound to its top level.
module dqp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_last_char,
   input logic        rsp_valid,
   input logic        rsp_stall
);

   // a held result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result transaction withdrawn while stalled");

   // the end of a string always yields an offered result
   a_last_yields: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last_char |-> ##2 rsp_valid)
      else $error("no result after final character");

   // a fresh result only follows a final character
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_last_char, 2))
      else $error("result without a final character");

endmodule

bind dotted_quad_to_ipv4_parser_top dqp_checker u_dqp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_last_char (req_last_char),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall)
);

/* tb/tb_dotted_quad_to_ipv4_parser_top.sv */
// Self-checking testbench for the dotted-quad IPv4 address parser.
`timescale 1ns / 100ps

module tb_dotted_quad_to_ipv4_parser_top;

   localparam int unsigned ACC_W        = 64;
   localparam logic [63:0] MAG_MASK     = {64{1'b1}} >> (64 - ACC_W);
   localparam int          ROWS         = 24;
   localparam int          RANDOM_CHARS = 900;
   // '~' in a directed row stands for a NUL character
   localparam logic [7:0]  NUL_MARK     = 8'h7E;
   localparam logic        PREDICTED    = 1'b0;
   localparam logic        KNOWN        = 1'b1;

   typedef struct packed {
      logic        known;
      logic [31:0] addr;
   } row_answer_type;

   localparam row_answer_type NO_ANSWER = {PREDICTED, 32'h0};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_in = 8'h00;
   logic        req_last_char = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_address;

   // parse state of the predictor
   logic [63:0]        tok_mag;
   logic               tok_sat;
   logic               tok_neg;
   dqp_pkg::base_type  tok_base;
   dqp_pkg::phase_type tok_phase;
   int unsigned        tok_count;
   logic [31:0]        addr_acc;

   logic [31:0] expected_addresses [$];
   logic [31:0] want_addr;
   logic [7:0]  text_buf [$];
   logic [9:0]  stall_tick;
   int          burst_left = 0;
   int          mismatches = 0;
   int          addresses_checked = 0;
   int          strings_sent = 0;
   int          chars_sent = 0;
   int          sat_tokens = 0;
   int          nul_cut = 0;

   string row_text [ROWS] = '{
      "1.2.3.4", "255.255.255.255", "0.0.0.0", "0x7f.010.9", " \t+12.-1", "..5...6.",
      "0x.0XG", "99999999999999999999999", "-0x10000000000000000", "-0xffffffffffffffff",
      "1.2.3.4.5.6", "7.8~9.1", "~", "+.-. \015.", "089.0Ab", "0X1F.0777.12z34",
      "- 5.\0137", "\377\200/:@G{", "\010\016", "0xAbCdEf.0x9",
      "18446744073709551615.18446744073709551616", "1", ".", "-1.-255.-256"
   };

   row_answer_type row_answer [ROWS] = '{
      {KNOWN, 32'h01020304}, {KNOWN, 32'hFFFFFFFF}, {KNOWN, 32'h00000000}, NO_ANSWER,
      {KNOWN, 32'h0CFF0000}, {KNOWN, 32'h05060000}, {KNOWN, 32'h00000000},
      {KNOWN, 32'hFF000000}, {KNOWN, 32'hFF000000}, NO_ANSWER,
      {KNOWN, 32'h01020304}, {KNOWN, 32'h07080000}, {KNOWN, 32'h00000000},
      {KNOWN, 32'h00000000}, {KNOWN, 32'h00000000}, NO_ANSWER, NO_ANSWER,
      {KNOWN, 32'h00000000}, {KNOWN, 32'h00000000}, NO_ANSWER,
      {KNOWN, 32'hFFFF0000}, {KNOWN, 32'h01000000}, {KNOWN, 32'h00000000}, NO_ANSWER
   };

   dotted_quad_to_ipv4_parser_top #(
      .ACC_BITS(ACC_W)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_char_in  (req_char_in),
      .req_last_char(req_last_char),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_address  (rsp_address)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void clear_parse();
      tok_mag   = '0;
      tok_sat   = 1'b0;
      tok_neg   = 1'b0;
      tok_base  = dqp_pkg::BASE_DEC;
      tok_phase = dqp_pkg::PH_BETWEEN;
      tok_count = 0;
      addr_acc  = '0;
   endfunction

   function automatic logic token_open();
      return tok_phase != dqp_pkg::PH_BETWEEN && tok_phase != dqp_pkg::PH_ENDED;
   endfunction

   function automatic int digit_value(input logic [7:0] ch, input dqp_pkg::base_type base);
      int d;
      d = -1;
      if (ch >= dqp_pkg::CHAR_ZERO && ch <= dqp_pkg::CHAR_NINE) begin
         d = int'(ch) - int'(dqp_pkg::CHAR_ZERO);
      end else if (ch >= dqp_pkg::CHAR_LA && ch <= dqp_pkg::CHAR_LF) begin
         d = int'(ch) - int'(dqp_pkg::CHAR_LA) + 10;
      end else if (ch >= dqp_pkg::CHAR_UA && ch <= dqp_pkg::CHAR_UF) begin
         d = int'(ch) - int'(dqp_pkg::CHAR_UA) + 10;
      end
      if (d < 0) return -1;
      if (base == dqp_pkg::BASE_OCT) return (d < 8) ? d : -1;
      if (base == dqp_pkg::BASE_HEX) return d;
      return (d < 10) ? d : -1;
   endfunction

   function automatic void shift_in_digit(input logic [63:0] d);
      logic [63:0] radix;
      radix = (tok_base == dqp_pkg::BASE_HEX) ? 64'd16 :
              (tok_base == dqp_pkg::BASE_OCT) ? 64'd8 : 64'd10;
      if (tok_sat) return;
      if (tok_mag > (MAG_MASK - d) / radix) tok_sat = 1'b1;
      else tok_mag = tok_mag * radix + d;
   endfunction

   function automatic void start_number(input dqp_pkg::base_type base, input logic [63:0] d);
      tok_base  = base;
      tok_phase = dqp_pkg::PH_DIGITS;
      shift_in_digit(d);
   endfunction

   function automatic void close_token();
      logic [63:0] v;
      if (tok_sat) begin
         v = MAG_MASK;
         sat_tokens++;
      end else if (tok_neg) begin
         v = (64'd0 - tok_mag) & MAG_MASK;
      end else begin
         v = tok_mag;
      end
      if (tok_count < dqp_pkg::TOKEN_SLOTS) begin
         addr_acc = addr_acc + (32'(v[7:0]) << (dqp_pkg::BYTE_BITS * (3 - tok_count)));
         tok_count++;
      end
      tok_mag  = '0;
      tok_sat  = 1'b0;
      tok_neg  = 1'b0;
      tok_base = dqp_pkg::BASE_DEC;
   endfunction

   function automatic void absorb_char(input logic [7:0] ch);
      int d;
      if (tok_phase == dqp_pkg::PH_ENDED) return;
      if (ch == dqp_pkg::CHAR_NUL) begin
         if (token_open()) close_token();
         tok_phase = dqp_pkg::PH_ENDED;
         nul_cut++;
         return;
      end
      if (ch == dqp_pkg::CHAR_DOT) begin
         if (token_open()) close_token();
         tok_phase = dqp_pkg::PH_BETWEEN;
         return;
      end
      if (tok_phase == dqp_pkg::PH_BETWEEN) tok_phase = dqp_pkg::PH_LEAD;
      if (tok_phase == dqp_pkg::PH_LEAD) begin
         if (ch == dqp_pkg::CHAR_SPACE ||
             (ch >= dqp_pkg::CHAR_TAB && ch <= dqp_pkg::CHAR_CR)) return;
         if (ch == dqp_pkg::CHAR_PLUS || ch == dqp_pkg::CHAR_MINUS) begin
            tok_neg   = (ch == dqp_pkg::CHAR_MINUS);
            tok_phase = dqp_pkg::PH_SIGNED;
            return;
         end
         // no sign: treat this character as the first one after a sign
         tok_phase = dqp_pkg::PH_SIGNED;
      end
      unique case (tok_phase)
         dqp_pkg::PH_SIGNED: begin
            if (ch == dqp_pkg::CHAR_ZERO) begin
               tok_phase = dqp_pkg::PH_ZERO;
            end else if (ch >= dqp_pkg::CHAR_ONE && ch <= dqp_pkg::CHAR_NINE) begin
               start_number(dqp_pkg::BASE_DEC, 64'(ch - dqp_pkg::CHAR_ZERO));
            end else begin
               tok_phase = dqp_pkg::PH_DONE;
            end
         end
         dqp_pkg::PH_ZERO: begin
            if (ch == dqp_pkg::CHAR_LX || ch == dqp_pkg::CHAR_UX) begin
               tok_phase = dqp_pkg::PH_XPEND;
            end else if (ch >= dqp_pkg::CHAR_ZERO && ch <= dqp_pkg::CHAR_SEVEN) begin
               start_number(dqp_pkg::BASE_OCT, 64'(ch - dqp_pkg::CHAR_ZERO));
            end else begin
               tok_phase = dqp_pkg::PH_DONE;
            end
         end
         dqp_pkg::PH_XPEND: begin
            d = digit_value(ch, dqp_pkg::BASE_HEX);
            if (d >= 0) start_number(dqp_pkg::BASE_HEX, 64'(d));
            else tok_phase = dqp_pkg::PH_DONE;
         end
         dqp_pkg::PH_DIGITS: begin
            d = digit_value(ch, tok_base);
            if (d >= 0) shift_in_digit(64'(d));
            else tok_phase = dqp_pkg::PH_DONE;
         end
         default: ;
      endcase
   endfunction

   function automatic void predict_address(input logic [7:0] ch, input logic last,
                                           output logic has_addr, output logic [31:0] addr);
      absorb_char(ch);
      has_addr = 1'b0;
      addr     = '0;
      if (last) begin
         if (token_open()) close_token();
         addr     = addr_acc;
         has_addr = 1'b1;
         clear_parse();
      end
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatches++;
   endtask

   // Hold the character until it is taken; idle between bursts of random length.
   task automatic send_char(input logic [7:0] ch, input logic last,
                            input row_answer_type answer);
      int          gap;
      logic        has_addr;
      logic [31:0] addr;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 15) : $urandom_range(0, 3);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 48);
      end
      req_valid     <= 1'b1;
      req_char_in   <= ch;
      req_last_char <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      chars_sent++;
      predict_address(ch, last, has_addr, addr);
      if (has_addr) expected_addresses.push_back(answer.known ? answer.addr : addr);
   endtask

   function automatic logic [7:0] rand_blank();
      int k;
      k = $urandom_range(0, 5);
      return (k == 0) ? dqp_pkg::CHAR_SPACE : dqp_pkg::CHAR_TAB + 8'(k - 1);
   endfunction

   function automatic logic [7:0] rand_hex_digit();
      int k;
      k = $urandom_range(0, 21);
      if (k < 10) return dqp_pkg::CHAR_ZERO + 8'(k);
      if (k < 16) return dqp_pkg::CHAR_LA + 8'(k - 10);
      return dqp_pkg::CHAR_UA + 8'(k - 16);
   endfunction

   function automatic void gen_token();
      int n;
      int kind;
      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 2)) text_buf.push_back(rand_blank());
      case ($urandom_range(0, 7))
         0: text_buf.push_back(dqp_pkg::CHAR_PLUS);
         1: text_buf.push_back(dqp_pkg::CHAR_MINUS);
         default: ;
      endcase
      // mostly short literals, now and then a long one that may saturate
      n    = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 24) : $urandom_range(1, 3);
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
         text_buf.push_back(dqp_pkg::CHAR_ONE + 8'($urandom_range(0, 8)));
         repeat (n - 1) text_buf.push_back(dqp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
      end else if (kind < 7) begin
         text_buf.push_back(dqp_pkg::CHAR_ZERO);
         repeat (n - 1) text_buf.push_back(dqp_pkg::CHAR_ZERO + 8'($urandom_range(0, 7)));
      end else if (kind < 9) begin
         text_buf.push_back(dqp_pkg::CHAR_ZERO);
         text_buf.push_back($urandom_range(0, 1) ? dqp_pkg::CHAR_LX : dqp_pkg::CHAR_UX);
         if ($urandom_range(0, 9) != 0) repeat (n) text_buf.push_back(rand_hex_digit());
      end else begin
         repeat (n) text_buf.push_back(8'($urandom_range(1, 255)));
      end
      if ($urandom_range(0, 7) == 0) text_buf.push_back(8'($urandom_range(1, 255)));
   endfunction

   function automatic void gen_string();
      int tokens;
      text_buf.delete();
      if ($urandom_range(0, 6) == 0) begin
         repeat ($urandom_range(1, 8)) text_buf.push_back(8'($urandom_range(0, 255)));
         return;
      end
      tokens = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 4;
      if ($urandom_range(0, 9) == 0) text_buf.push_back(dqp_pkg::CHAR_DOT);
      for (int t = 0; t < tokens; t++) begin
         if (t > 0) begin
            text_buf.push_back(dqp_pkg::CHAR_DOT);
            if ($urandom_range(0, 9) == 0) text_buf.push_back(dqp_pkg::CHAR_DOT);
         end
         gen_token();
      end
      if ($urandom_range(0, 9) == 0) text_buf.push_back(dqp_pkg::CHAR_DOT);
      if ($urandom_range(0, 14) == 0)
         text_buf.insert($urandom_range(0, text_buf.size() - 1), dqp_pkg::CHAR_NUL);
   endfunction

   // Receiver stall pattern: quiet, light random, long periodic, heavy random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_tick <= '0;
      end else begin
         stall_tick <= stall_tick + 1'b1;
         case (stall_tick[9:8])
            2'd0: rsp_stall <= 1'b0;
            2'd1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2'd2: rsp_stall <= (stall_tick[3:0] < 4'd11);
            default: rsp_stall <= ($urandom_range(0, 4) < 3);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_addresses.size() == 0) begin
            report_mismatch($sformatf("address %h with nothing outstanding", rsp_address));
         end else begin
            want_addr = expected_addresses.pop_front();
            if (rsp_address !== want_addr)
               report_mismatch($sformatf("address %h, want %h", rsp_address, want_addr));
            addresses_checked++;
         end
      end
   end

   initial begin : stimulus
      string      text;
      logic [7:0] ch;
      int         random_chars;
      random_chars = 0;
      clear_parse();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < ROWS; r++) begin
         text = row_text[r];
         for (int i = 0; i < text.len(); i++) begin
            ch = text[i];
            if (ch == NUL_MARK) ch = dqp_pkg::CHAR_NUL;
            send_char(ch, i == text.len() - 1, row_answer[r]);
         end
         strings_sent++;
      end

      while (random_chars < RANDOM_CHARS) begin
         gen_string();
         foreach (text_buf[i]) send_char(text_buf[i], i == text_buf.size() - 1, NO_ANSWER);
         random_chars += text_buf.size();
         strings_sent++;
      end

      req_valid <= 1'b0;
      while (expected_addresses.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Parsed %0d strings of %0d characters; %0d addresses compared.",
               strings_sent, chars_sent, addresses_checked);
      $display("Saturated tokens: %0d, strings cut by NUL: %0d, mismatches: %0d.",
               sat_tokens, nul_cut, mismatches);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Timeout with %0d addresses outstanding", expected_addresses.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule

/* dotted_quad_to_ipv4_parser_top.f */
src/dqp_pkg.sv
src/dotted_quad_to_ipv4_parser_top.sv
src/dqp_checker.sv
tb/tb_dotted_quad_to_ipv4_parser_top.sv
